// ----- rtl/core/gf256_lfsr_byte_generator_defines.svh -----
// Assertion macros shared by the byte generator RTL.
`ifndef GF256_LFSR_BYTE_GENERATOR_DEFINES_SVH
`define GF256_LFSR_BYTE_GENERATOR_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define GFL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition holds at every clock edge, reset included.
`define GFL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/gflfsr_pkg.sv -----
// Shared constants and the GF(2^8) multiply function of the byte generator.
package gflfsr_pkg;

    localparam int DEGREE      = 8;
    localparam int STORE_DEPTH = 8;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BYTE_W      = 8;
    localparam int TAPS_W      = 64;
    localparam int OPC_W       = 2;

    localparam logic [ADDR_W:0]   DEGREE_CNT = (ADDR_W + 1)'(DEGREE);
    localparam logic [ADDR_W-1:0] LAST_POS   = ADDR_W'(DEGREE - 1);

    localparam logic [OPC_W-1:0] OP_NEXT    = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [OPC_W-1:0] OP_DEFAULT = 2'd2;

    localparam logic [TAPS_W-1:0] TAPS_RESET = 64'd257;
    localparam logic [BYTE_W-1:0] POLY_RESET = 8'd29;

    localparam logic CFG_TAPS = 1'b0;
    localparam logic CFG_POLY = 1'b1;

    // Shift-and-add multiply, reducing by x^8 plus the low polynomial bits.
    function automatic logic [BYTE_W-1:0] gf_mul(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] acc;
        logic              carry;
        x   = a;
        acc = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            carry = x[BYTE_W-1];
            x     = {x[BYTE_W-2:0], 1'b0};
            if (carry) begin
                x = x ^ poly;
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/core/gflfsr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module gflfsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/gf256_lfsr_byte_generator.sv -----
// Top level of the GF(2^8) linear recurrence byte generator.
//
//   channel   signals                                   direction
//   input     i_in_valid / o_in_ready, opcode, entry    in
//   output    o_out_valid / i_out_ready, random_byte    out
//   config    i_cfg_we, i_cfg_addr, i_cfg_data          in
//
// A next word passes through the accept cycle, one store read per tap, a drain
// step for the last product and a write-back step. Load and default words are
// handled in the accept cycle and leave the generator idle.
// Reset restores the taps, the polynomial and the head, and marks every store entry
// as holding its own index, so no clearing pass is needed.
// A stalled output holds the finished byte; a further next word waits in write-back.
`include "gf256_lfsr_byte_generator_defines.svh"

module gf256_lfsr_byte_generator
    import gflfsr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OPC_W-1:0]    i_opcode,
    input  logic [ADDR_W-1:0]   i_entry_index,
    input  logic [BYTE_W-1:0]   i_entry_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [BYTE_W-1:0]   o_random_byte,
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [TAPS_W-1:0]   i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [TAPS_W-1:0]      r_taps;
    logic [BYTE_W-1:0]      r_poly;
    logic [STORE_DEPTH-1:0] r_written;
    logic [ADDR_W-1:0]      r_head, n_head;
    logic [ADDR_W-1:0]      r_pos;
    logic [ADDR_W-1:0]      r_cnt;
    logic [ADDR_W-1:0]      r_tap_idx;
    logic [ADDR_W-1:0]      r_rd_addr;
    logic                   r_rd_vld;
    logic                   r_rd_pend;
    logic [BYTE_W-1:0]      r_acc;
    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_out_byte;

    logic                   in_fire;
    logic                   done_go;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [BYTE_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [BYTE_W-1:0]      ram_rdata;
    logic [BYTE_W-1:0]      rd_byte;
    logic [BYTE_W-1:0]      tap_byte;
    logic [BYTE_W-1:0]      product;
    logic [ADDR_W-1:0]      pos_next;
    logic                   load_hit;

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_fire       = i_in_valid && o_in_ready;
    assign done_go       = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid   = r_out_valid;
    assign o_random_byte = r_out_byte;

    assign load_hit = in_fire && (i_opcode == OP_LOAD)
                    && ({1'b0, i_entry_index} < DEGREE_CNT);
    assign ram_we    = load_hit || done_go;
    assign ram_waddr = done_go ? r_head : i_entry_index;
    assign ram_wdata = done_go ? r_acc : i_entry_value;
    assign ram_re    = (r_state == S_RUN);
    assign pos_next  = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;

    assign rd_byte  = r_rd_vld ? ram_rdata : BYTE_W'(r_rd_addr);
    assign tap_byte = r_taps[BYTE_W * r_tap_idx +: BYTE_W];
    assign product  = gf_mul(tap_byte, rd_byte, r_poly);

    gflfsr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_opcode == OP_NEXT) begin
                        n_state = S_RUN;
                    end else if (i_opcode == OP_LOAD || i_opcode == OP_DEFAULT) begin
                        n_head = '0;
                    end
                end
            end
            S_RUN: begin
                if (r_cnt == LAST_POS) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (done_go) begin
                    n_state = S_IDLE;
                    n_head  = (r_head == LAST_POS) ? '0 : r_head + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_taps      <= TAPS_RESET;
            r_poly      <= POLY_RESET;
            r_written   <= '0;
            r_head      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_rd_pend <= ram_re;
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_TAPS) begin
                    r_taps <= i_cfg_data;
                end else begin
                    r_poly <= i_cfg_data[BYTE_W-1:0];
                end
            end
            if (in_fire && i_opcode == OP_DEFAULT) begin
                r_written <= '0;
            end else if (ram_we) begin
                r_written[ram_waddr] <= 1'b1;
            end
            if (done_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pos <= r_head;
            r_cnt <= '0;
            r_acc <= '0;
        end else begin
            if (ram_re) begin
                r_pos <= pos_next;
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_rd_pend) begin
                r_acc <= r_acc ^ product;
            end
        end
        if (ram_re) begin
            r_rd_addr <= r_pos;
            r_rd_vld  <= r_written[r_pos];
            r_tap_idx <= r_cnt;
        end
        if (done_go) begin
            r_out_byte <= r_acc;
        end
    end

    `GFL_ASSERT(a_head_in_range, ({1'b0, r_head} < DEGREE_CNT), "head out of range")
    `GFL_ASSERT(a_next_starts_run, (in_fire && i_opcode == OP_NEXT) |=> (r_state == S_RUN),
                "next word did not start the tap walk")
    `GFL_ASSERT(a_read_pending_in_walk, r_rd_pend |-> (r_state == S_RUN || r_state == S_LAST),
                "store read data arrived outside the tap walk")
    `GFL_ASSERT(a_result_from_done, $rose(o_out_valid) |-> ($past(r_state) == S_DONE),
                "result appeared without a write-back")

endmodule
